### src/lslh_pkg.sv
`timescale 1ns / 1ps
// Shared types, sizes, command codes and bucket function for the log2
// latency histogram. No dependencies.
package lslh_pkg;

   localparam int BUCKETS     = 16;
   localparam int COUNT_WIDTH = 32;
   localparam int BKT_W       = $clog2(BUCKETS);

   typedef logic [1:0]             cmd_type;
   typedef logic [63:0]            sample_type;
   typedef logic [3:0]             sel_type;
   typedef logic [31:0]            tally_type;
   typedef logic [BKT_W-1:0]       bkt_idx_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;

   localparam cmd_type CMD_RECORD = 2'd0;
   localparam cmd_type CMD_READ   = 2'd1;
   localparam cmd_type CMD_CLEAR  = 2'd2;

   typedef struct packed {
      tally_type  step_total;
      sample_type cycle_sum;
      sample_type cycle_peak;
      sample_type cycle_floor;
      sel_type    bucket_number;
      tally_type  bucket_tally;
   } rsp_type;

   // floor(log2(s)) clamped to the last bucket; 0 and 1 map to bucket 0
   function automatic bkt_idx_type bucket_of(input sample_type s);
      bkt_idx_type b;
      b = '0;
      for (int k = 1; k < BUCKETS; k++) begin
         if ((s >> k) != 64'd0) begin
            b = bkt_idx_type'(k);
         end
      end
      return b;
   endfunction

   function automatic count_type sat_inc(input count_type v);
      count_type r;
      r = (v == '1) ? v : v + count_type'(1);
      return r;
   endfunction

endpackage

### src/lslh_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
module lslh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/latency_stats_log2_histogram.sv
`timescale 1ns / 1ps
// The bucket RAM read and the stage register load at the edge that accepts a request; the
// stage then feeds the response register, or the skid entry while the response register
// holds a stalled response. Throughput: one request per cycle while req_stall is low; the
// bucket RAM read-modify-write forwards the previous write when both touch the same bucket.
// Reset: all statistics zero, bucket valid flags cleared at once (no clearing
// pass), meter disabled. Uses lslh_pkg and lslh_ram.
module latency_stats_log2_histogram (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  lslh_pkg::cmd_type     req_cmd,
   input  lslh_pkg::sample_type  req_sample_cycles,
   input  lslh_pkg::sel_type     req_bucket_select,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output lslh_pkg::tally_type   rsp_step_total,
   output lslh_pkg::sample_type  rsp_cycle_sum,
   output lslh_pkg::sample_type  rsp_cycle_peak,
   output lslh_pkg::sample_type  rsp_cycle_floor,
   output lslh_pkg::sel_type     rsp_bucket_number,
   output lslh_pkg::tally_type   rsp_bucket_tally,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_meter_enabled
);

   logic                         req_accept;
   lslh_pkg::bkt_idx_type        rd_addr;
   logic                         in_range;

   logic                         enable_ff;

   logic                         stg_valid_ff;
   lslh_pkg::cmd_type            stg_cmd_ff;
   lslh_pkg::sample_type         stg_sample_ff;
   lslh_pkg::sel_type            stg_sel_ff;
   lslh_pkg::bkt_idx_type        stg_bkt_ff;
   logic                         stg_in_range_ff;
   logic                         fwd_hit_ff;
   lslh_pkg::count_type          fwd_data_ff;

   logic [lslh_pkg::BUCKETS-1:0] bkt_valid_ff;
   logic [lslh_pkg::BUCKETS-1:0] bkt_valid_in;

   lslh_pkg::count_type          steps_ff, steps_in;
   lslh_pkg::sample_type         sum_ff, sum_in;
   lslh_pkg::sample_type         peak_ff, peak_in;
   lslh_pkg::sample_type         floor_ff, floor_in;

   lslh_pkg::count_type          ram_rd_data;
   lslh_pkg::count_type          cur_count;
   lslh_pkg::count_type          new_count;
   logic                         wr_en;
   logic                         do_record;
   logic                         do_clear;
   lslh_pkg::rsp_type            stg_rsp;

   logic                         out0_valid_ff, out0_valid_in;
   logic                         out1_valid_ff, out1_valid_in;
   lslh_pkg::rsp_type            out0_ff, out0_in;
   lslh_pkg::rsp_type            out1_ff, out1_in;
   logic                         pop;
   logic [1:0]                   occ_next;

   // request side
   assign req_accept = req_valid && !req_stall;
   assign rd_addr    = (req_cmd == lslh_pkg::CMD_RECORD) ?
                       lslh_pkg::bucket_of(req_sample_cycles) :
                       lslh_pkg::bkt_idx_type'(req_bucket_select);
   assign in_range   = ({28'd0, req_bucket_select} < 32'(lslh_pkg::BUCKETS));

   assign pop      = out0_valid_ff && !rsp_stall;
   assign occ_next = {1'b0, out0_valid_ff} + {1'b0, out1_valid_ff}
                     + {1'b0, stg_valid_ff} - {1'b0, pop};
   assign req_stall = occ_next[1];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         enable_ff <= csr_meter_enabled;
      end
   end

   lslh_ram #(
      .WIDTH(lslh_pkg::COUNT_WIDTH),
      .DEPTH(lslh_pkg::BUCKETS)
   ) u_bucket_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(stg_bkt_ff),
      .wr_data(new_count),
      .rd_en  (req_accept),
      .rd_addr(rd_addr),
      .rd_data(ram_rd_data)
   );

   // stage after the RAM read
   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
         fwd_hit_ff   <= 1'b0;
      end else begin
         stg_valid_ff <= req_accept;
         fwd_hit_ff   <= req_accept && wr_en && (stg_bkt_ff == rd_addr);
      end
      if (req_accept) begin
         stg_cmd_ff      <= req_cmd;
         stg_sample_ff   <= req_sample_cycles;
         stg_sel_ff      <= req_bucket_select;
         stg_bkt_ff      <= rd_addr;
         stg_in_range_ff <= in_range;
         fwd_data_ff     <= new_count;
      end
   end

   always_comb begin
      do_record = stg_valid_ff && (stg_cmd_ff == lslh_pkg::CMD_RECORD) && enable_ff;
      do_clear  = stg_valid_ff && (stg_cmd_ff == lslh_pkg::CMD_CLEAR);
      wr_en     = do_record;

      if (fwd_hit_ff) begin
         cur_count = fwd_data_ff;
      end else if (bkt_valid_ff[stg_bkt_ff]) begin
         cur_count = ram_rd_data;
      end else begin
         cur_count = '0;
      end
      new_count = lslh_pkg::sat_inc(cur_count);

      bkt_valid_in = bkt_valid_ff;
      steps_in     = steps_ff;
      sum_in       = sum_ff;
      peak_in      = peak_ff;
      floor_in     = floor_ff;
      if (do_clear) begin
         bkt_valid_in = '0;
         steps_in     = '0;
         sum_in       = '0;
         peak_in      = '0;
         floor_in     = '0;
      end else if (do_record) begin
         bkt_valid_in[stg_bkt_ff] = 1'b1;
         steps_in = lslh_pkg::sat_inc(steps_ff);
         sum_in   = sum_ff + stg_sample_ff;
         if (stg_sample_ff > peak_ff) begin
            peak_in = stg_sample_ff;
         end
         if ((floor_ff == 64'd0) || (stg_sample_ff < floor_ff)) begin
            floor_in = stg_sample_ff;
         end
      end

      stg_rsp.step_total  = lslh_pkg::tally_type'(steps_in);
      stg_rsp.cycle_sum   = sum_in;
      stg_rsp.cycle_peak  = peak_in;
      stg_rsp.cycle_floor = floor_in;
      case (stg_cmd_ff)
         lslh_pkg::CMD_RECORD: begin
            stg_rsp.bucket_number = lslh_pkg::sel_type'(stg_bkt_ff);
            stg_rsp.bucket_tally  = enable_ff ? lslh_pkg::tally_type'(new_count) :
                                                lslh_pkg::tally_type'(cur_count);
         end
         lslh_pkg::CMD_CLEAR: begin
            stg_rsp.bucket_number = '0;
            stg_rsp.bucket_tally  = '0;
         end
         default: begin
            stg_rsp.bucket_number = stg_sel_ff;
            stg_rsp.bucket_tally  = stg_in_range_ff ? lslh_pkg::tally_type'(cur_count) :
                                                      '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bkt_valid_ff <= '0;
         steps_ff     <= '0;
         sum_ff       <= '0;
         peak_ff      <= '0;
         floor_ff     <= '0;
      end else begin
         bkt_valid_ff <= bkt_valid_in;
         steps_ff     <= steps_in;
         sum_ff       <= sum_in;
         peak_ff      <= peak_in;
         floor_ff     <= floor_in;
      end
   end

   // response register plus skid entry
   always_comb begin
      out0_valid_in = out0_valid_ff;
      out1_valid_in = out1_valid_ff;
      out0_in       = out0_ff;
      out1_in       = out1_ff;
      if (pop) begin
         if (out1_valid_ff) begin
            out0_in = out1_ff;
            if (stg_valid_ff) begin
               out1_in = stg_rsp;
            end else begin
               out1_valid_in = 1'b0;
            end
         end else if (stg_valid_ff) begin
            out0_in = stg_rsp;
         end else begin
            out0_valid_in = 1'b0;
         end
      end else if (stg_valid_ff) begin
         if (!out0_valid_ff) begin
            out0_valid_in = 1'b1;
            out0_in       = stg_rsp;
         end else begin
            out1_valid_in = 1'b1;
            out1_in       = stg_rsp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out0_valid_ff <= 1'b0;
         out1_valid_ff <= 1'b0;
      end else begin
         out0_valid_ff <= out0_valid_in;
         out1_valid_ff <= out1_valid_in;
      end
      out0_ff <= out0_in;
      out1_ff <= out1_in;
   end

   assign rsp_valid         = out0_valid_ff;
   assign rsp_step_total    = out0_ff.step_total;
   assign rsp_cycle_sum     = out0_ff.cycle_sum;
   assign rsp_cycle_peak    = out0_ff.cycle_peak;
   assign rsp_cycle_floor   = out0_ff.cycle_floor;
   assign rsp_bucket_number = out0_ff.bucket_number;
   assign rsp_bucket_tally  = out0_ff.bucket_tally;

   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      out1_valid_ff |-> out0_valid_ff)
      else $error("skid entry valid without response register");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(stg_valid_ff && out1_valid_ff && rsp_stall))
      else $error("response buffer overflow");

   a_fwd_needs_stage: assert property (@(posedge clock) disable iff (reset)
      fwd_hit_ff |-> stg_valid_ff)
      else $error("forward hit without an item in the stage");

   a_clear_flags: assert property (@(posedge clock) disable iff (reset)
      do_clear |=> (bkt_valid_ff == '0) && (steps_ff == '0))
      else $error("clear left bucket flags or step count set");

endmodule
